/* rtl/core/fbde_pkg.sv */
// Shared types, widths and codes for the framebuffer draw engine.
`default_nettype none

package fbde_pkg;

    localparam int FB_BYTES_DEF   = 262144;
    localparam int COORD_BITS_DEF = 16;

    localparam int CMD_W      = 3;
    localparam int COORD_W    = 16;
    localparam int RECT_W     = 12;
    localparam int COLOR_W    = 32;
    localparam int DIM_W      = 13;
    localparam int PITCH_W    = 15;
    localparam int PB_W       = 3;
    localparam int CALC_W     = 18;
    localparam int PROD_W     = 28;
    localparam int ADDR_W     = 29;
    localparam int WIDX_W     = 22;
    localparam int XOFF_W     = DIM_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 40;

    localparam logic [COLOR_W-1:0] COLOR_KEY = 32'h00FF_00FF;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd256;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd256;
    localparam logic [PITCH_W-1:0] PITCH_RST  = 15'd1024;
    localparam logic [PB_W-1:0]    PB_RST     = 3'd4;
    localparam logic [PB_W-1:0]    PB_WIDE    = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT,
        CMD_GET,
        CMD_FILL,
        CMD_CLEAR,
        CMD_BLIT_START,
        CMD_BLIT_PIXEL
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_PITCH,
        CFG_PIXEL_BYTES
    } cfg_idx_t;

    // one pixel access into the frame store
    typedef struct packed {
        logic               valid;
        logic               write;
        logic               last;
        logic               raw;
        logic               wide;
        logic [DIM_W-1:0]   px;
        logic [DIM_W-1:0]   py;
        logic [WIDX_W-1:0]  word_idx;
        logic [COLOR_W-1:0] color;
    } op_t;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] data;
    } resp_t;

    function automatic logic on_screen(
        input logic signed [CALC_W-1:0] x,
        input logic signed [CALC_W-1:0] y,
        input logic [DIM_W-1:0]         sw,
        input logic [DIM_W-1:0]         sh
    );
        logic [CALC_W-2:0] swe;
        logic [CALC_W-2:0] she;
        swe = '0;
        she = '0;
        swe[DIM_W-1:0] = sw;
        she[DIM_W-1:0] = sh;
        return !x[CALC_W-1] && !y[CALC_W-1] &&
               (x[CALC_W-2:0] < swe) && (y[CALC_W-2:0] < she);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fbde_store.sv */
// Byte-lane frame store with address pipeline and clearing pass after reset.
`default_nettype none

module fbde_store #(
    parameter int FB_BYTES = fbde_pkg::FB_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fbde_pkg::op_t                   op,
    input  wire logic [fbde_pkg::PITCH_W-1:0]    pitch,
    output logic                                 busy,
    output fbde_pkg::resp_t                      resp
);

    localparam int ROWS = (FB_BYTES + 3) / 4;
    localparam int RB   = $clog2(ROWS);
    localparam int AW   = fbde_pkg::ADDR_W;
    localparam int PW   = fbde_pkg::PROD_W;
    localparam int XW   = fbde_pkg::XOFF_W;
    localparam int CW   = fbde_pkg::COLOR_W;
    localparam logic [AW-1:0] FB_LIMIT = AW'(FB_BYTES);
    localparam logic [RB-1:0] LAST_ROW = RB'(ROWS - 1);

    logic          clr_active_reg;
    logic [RB-1:0] clr_row_reg;

    logic          s1_valid_reg, s1_write_reg, s1_last_reg, s1_wide_reg;
    logic [CW-1:0] s1_color_reg;
    logic [PW-1:0] s1_prod_reg;
    logic [XW-1:0] s1_xoff_reg;

    logic          s2_valid_reg, s2_write_reg, s2_last_reg, s2_wide_reg;
    logic [CW-1:0] s2_color_reg;
    logic [AW-1:0] s2_addr_reg;

    logic          s3_valid_reg, s3_last_reg;
    logic [3:0]    s3_en_reg;
    logic [1:0]    s3_k_reg [4];

    logic [PW-1:0] mul;
    logic [PW-1:0] prod_next;
    logic [XW-1:0] xoff_next;
    logic [AW-1:0] addr_next;

    logic [1:0]    lane_k    [4];
    logic [AW-1:0] byte_addr [4];
    logic [RB-1:0] lane_row  [4];
    logic [7:0]    wr_byte   [4];
    logic [7:0]    rd_data   [4];
    logic [3:0]    lane_en;
    logic [CW-1:0] rd_word;

    assign busy = clr_active_reg;
    assign mul  = op.py * pitch;

    always_comb
    begin
        if (op.raw)
        begin
            prod_next = '0;
            prod_next[fbde_pkg::WIDX_W+1:0] = {op.word_idx, 2'b00};
            xoff_next = '0;
        end
        else
        begin
            prod_next = mul;
            if (op.wide)
                xoff_next = {op.px, 2'b00};
            else
                xoff_next = {2'b00, op.px} + {1'b0, op.px, 1'b0};
        end
    end

    assign addr_next = {1'b0, s1_prod_reg} + {{(AW - XW){1'b0}}, s1_xoff_reg};

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            lane_k[j]    = 2'(j) - s2_addr_reg[1:0];
            byte_addr[j] = s2_addr_reg + {{(AW - 2){1'b0}}, lane_k[j]};
            lane_en[j]   = s2_valid_reg && (s2_wide_reg || lane_k[j] != 2'd3) &&
                           (byte_addr[j] < FB_LIMIT);
            lane_row[j]  = byte_addr[j][RB+1:2];
            wr_byte[j]   = s2_color_reg[{lane_k[j], 3'b000} +: 8];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            logic [7:0] mem [ROWS];
            logic [7:0] rd_q_reg;

            always_ff @(posedge clk)
            begin
                if (clr_active_reg)
                    mem[clr_row_reg] <= '0;
                else if (lane_en[g] && s2_write_reg)
                    mem[lane_row[g]] <= wr_byte[g];
                rd_q_reg <= mem[lane_row[g]];
            end

            assign rd_data[g] = rd_q_reg;
        end
    endgenerate

    always_comb
    begin
        rd_word = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (s3_en_reg[j])
                rd_word[{s3_k_reg[j], 3'b000} +: 8] = rd_data[j];
        end
    end

    assign resp.valid = s3_valid_reg && s3_last_reg;
    assign resp.data  = rd_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_row_reg == LAST_ROW)
                    clr_active_reg <= 1'b0;
                else
                    clr_row_reg <= clr_row_reg + 1'b1;
            end
            s1_valid_reg <= op.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_write_reg <= op.write;
        s1_last_reg  <= op.last;
        s1_wide_reg  <= op.wide;
        s1_color_reg <= op.color;
        s1_prod_reg  <= prod_next;
        s1_xoff_reg  <= xoff_next;

        s2_write_reg <= s1_write_reg;
        s2_last_reg  <= s1_last_reg;
        s2_wide_reg  <= s1_wide_reg;
        s2_color_reg <= s1_color_reg;
        s2_addr_reg  <= addr_next;

        s3_last_reg  <= s2_last_reg;
        s3_en_reg    <= lane_en;
        for (int j = 0; j < 4; j++)
            s3_k_reg[j] <= lane_k[j];
    end

endmodule

`default_nettype wire

/* rtl/core/framebuffer_draw_engine_unit.sv */
// Top level: command sequencer, configuration registers and result register.
// Commands that touch the store wait in ST_WAIT for its response, which comes
// through op_reg and stages s1, s2, s3; other commands go to ST_RESULT directly.
// Fill and clear issue one pixel (or one 32-bit word) per cycle through the store
// pipeline, then drain it in ST_WAIT; one item is in work at a time.
// Reset: the store clearing pass writes one row of four bytes per cycle until all
// ROWS rows are cleared, during which s_tready stays low.
`default_nettype none

module framebuffer_draw_engine_unit #(
    parameter int FB_BYTES   = fbde_pkg::FB_BYTES_DEF,
    parameter int COORD_BITS = fbde_pkg::COORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // x_pos[15:0], y_pos[31:16], rect_width[43:32], rect_height[55:44], color[87:56]
    input  wire logic [fbde_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[2:0]
    input  wire logic [fbde_pkg::CMD_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pixel_value[31:0], in_range[32], zero[39:33]
    output logic [fbde_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fbde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fbde_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW    = fbde_pkg::CALC_W;
    localparam int DW    = fbde_pkg::DIM_W;
    localparam int RW    = fbde_pkg::RECT_W;
    localparam int KW    = fbde_pkg::COORD_W;
    localparam int PW    = fbde_pkg::PROD_W;
    localparam int WW    = PW - 2;
    localparam int ROWS  = (FB_BYTES + 3) / 4;
    localparam int RB    = $clog2(ROWS);
    localparam logic [WW-1:0] MAX_WORDS = WW'(FB_BYTES / 4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_WAIT,
        ST_RESULT
    } state_t;

    // configuration
    logic [DW-1:0]                   width_reg, height_reg;
    logic [fbde_pkg::PITCH_W-1:0]    pitch_reg;
    logic [fbde_pkg::PB_W-1:0]       pbytes_reg;

    state_t                          state_reg, state_next;
    fbde_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [KW-1:0]                   x_reg, x_next, y_reg, y_next;
    logic [RW-1:0]                   w_reg, w_next, h_reg, h_next;
    logic [fbde_pkg::COLOR_W-1:0]    color_reg, color_next;

    logic [KW-1:0]                   borg_x_reg, borg_x_next, borg_y_reg, borg_y_next;
    logic [RW-1:0]                   bw_reg, bw_next, bh_reg, bh_next;
    logic [RW-1:0]                   bcol_reg, bcol_next, brow_reg, brow_next;

    logic [DW-1:0]                   cx_reg, cx_next, cy_reg, cy_next;
    logic [DW-1:0]                   x0_reg, x0_next, x1m_reg, x1m_next, y1m_reg, y1m_next;
    logic                            raw_reg, raw_next;
    logic [RB-1:0]                   word_reg, word_next, word_last_reg, word_last_next;

    fbde_pkg::op_t                   op_reg, op_next;
    logic [fbde_pkg::COLOR_W-1:0]    res_value_reg, res_value_next;
    logic                            res_ok_reg, res_ok_next;
    logic                            m_valid_reg, m_valid_next;
    logic [fbde_pkg::COLOR_W-1:0]    out_value_reg, out_value_next;
    logic                            out_ok_reg, out_ok_next;

    logic                            store_busy;
    fbde_pkg::resp_t                 resp;

    logic                            wide;
    logic signed [CW-1:0]            xs, ys, swe, she;
    logic                            pix_in;
    logic                            is_clear;
    logic signed [CW-1:0]            fx, fy, fwe, fhe, fxe, fye;
    logic signed [CW-1:0]            fx0, fy0, fx1, fy1, fx1m, fy1m;
    logic                            fill_any;
    logic [PW-1:0]                   cw_prod;
    logic [WW-1:0]                   cw_cnt, cw_last;
    logic                            bact, bin, bdraw, bwrap;
    logic signed [CW-1:0]            bpx, bpy;
    logic [RW:0]                     bcol_inc;
    logic                            run_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !store_busy;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'b0, out_ok_reg, out_value_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fbde_pkg::WIDTH_RST;
            height_reg <= fbde_pkg::HEIGHT_RST;
            pitch_reg  <= fbde_pkg::PITCH_RST;
            pbytes_reg <= fbde_pkg::PB_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fbde_pkg::cfg_idx_t'(cfg_index))
                fbde_pkg::CFG_WIDTH:       width_reg  <= cfg_data[DW-1:0];
                fbde_pkg::CFG_HEIGHT:      height_reg <= cfg_data[DW-1:0];
                fbde_pkg::CFG_PITCH:       pitch_reg  <= cfg_data;
                fbde_pkg::CFG_PIXEL_BYTES: pbytes_reg <= cfg_data[fbde_pkg::PB_W-1:0];
                default: ;
            endcase
        end
    end

    // decode datapath
    assign wide = (pbytes_reg == fbde_pkg::PB_WIDE);
    assign xs   = {{(CW - COORD_BITS){x_reg[COORD_BITS-1]}}, x_reg[COORD_BITS-1:0]};
    assign ys   = {{(CW - COORD_BITS){y_reg[COORD_BITS-1]}}, y_reg[COORD_BITS-1:0]};
    assign swe  = {{(CW - DW){1'b0}}, width_reg};
    assign she  = {{(CW - DW){1'b0}}, height_reg};
    assign pix_in = fbde_pkg::on_screen(xs, ys, width_reg, height_reg);

    assign is_clear = (cmd_reg == fbde_pkg::CMD_CLEAR);
    assign fx   = is_clear ? '0 : xs;
    assign fy   = is_clear ? '0 : ys;
    assign fwe  = is_clear ? swe : {{(CW - RW){1'b0}}, w_reg};
    assign fhe  = is_clear ? she : {{(CW - RW){1'b0}}, h_reg};
    assign fxe  = fx + fwe;
    assign fye  = fy + fhe;
    assign fx0  = fx[CW-1] ? '0 : fx;
    assign fy0  = fy[CW-1] ? '0 : fy;
    assign fx1  = (fxe > swe) ? swe : fxe;
    assign fy1  = (fye > she) ? she : fye;
    assign fx1m = fx1 - 1'b1;
    assign fy1m = fy1 - 1'b1;
    assign fill_any = (fx1 > fx0) && (fy1 > fy0);

    assign cw_prod = pitch_reg * height_reg;
    assign cw_cnt  = (cw_prod[PW-1:2] > MAX_WORDS) ? MAX_WORDS : cw_prod[PW-1:2];
    assign cw_last = cw_cnt - 1'b1;

    assign bact  = (bw_reg != '0) && (brow_reg < bh_reg);
    assign bpx   = {{(CW - COORD_BITS){borg_x_reg[COORD_BITS-1]}},
                    borg_x_reg[COORD_BITS-1:0]} + {{(CW - RW){1'b0}}, bcol_reg};
    assign bpy   = {{(CW - COORD_BITS){borg_y_reg[COORD_BITS-1]}},
                    borg_y_reg[COORD_BITS-1:0]} + {{(CW - RW){1'b0}}, brow_reg};
    assign bin   = fbde_pkg::on_screen(bpx, bpy, width_reg, height_reg);
    assign bdraw = bin && (color_reg != fbde_pkg::COLOR_KEY);
    assign bcol_inc = {1'b0, bcol_reg} + 1'b1;
    assign bwrap = (bcol_inc >= {1'b0, bw_reg});

    assign run_last = raw_reg ? (word_reg == word_last_reg)
                              : ((cx_reg == x1m_reg) && (cy_reg == y1m_reg));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        color_next     = color_reg;
        borg_x_next    = borg_x_reg;
        borg_y_next    = borg_y_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        bcol_next      = bcol_reg;
        brow_next      = brow_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x0_next        = x0_reg;
        x1m_next       = x1m_reg;
        y1m_next       = y1m_reg;
        raw_next       = raw_reg;
        word_next      = word_reg;
        word_last_next = word_last_reg;
        res_value_next = res_value_reg;
        res_ok_next    = res_ok_reg;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        op_next        = '0;
        op_next.wide   = wide;
        op_next.color  = color_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd_next   = fbde_pkg::cmd_t'(s_tuser);
                    x_next     = s_tdata[15:0];
                    y_next     = s_tdata[31:16];
                    w_next     = s_tdata[43:32];
                    h_next     = s_tdata[55:44];
                    color_next = s_tdata[87:56];
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_value_next = '0;
                res_ok_next    = 1'b0;
                state_next     = ST_RESULT;
                case (cmd_reg)
                    fbde_pkg::CMD_PUT, fbde_pkg::CMD_GET:
                    begin
                        if (pix_in)
                        begin
                            op_next.valid = 1'b1;
                            op_next.write = (cmd_reg == fbde_pkg::CMD_PUT);
                            op_next.last  = 1'b1;
                            op_next.px    = xs[DW-1:0];
                            op_next.py    = ys[DW-1:0];
                            res_ok_next   = 1'b1;
                            state_next    = ST_WAIT;
                        end
                    end
                    fbde_pkg::CMD_FILL, fbde_pkg::CMD_CLEAR:
                    begin
                        if (is_clear && wide)
                        begin
                            raw_next       = 1'b1;
                            word_next      = '0;
                            word_last_next = cw_last[RB-1:0];
                            if (cw_cnt != '0)
                                state_next = ST_RUN;
                        end
                        else
                        begin
                            raw_next = 1'b0;
                            cx_next  = fx0[DW-1:0];
                            cy_next  = fy0[DW-1:0];
                            x0_next  = fx0[DW-1:0];
                            x1m_next = fx1m[DW-1:0];
                            y1m_next = fy1m[DW-1:0];
                            if (fill_any)
                                state_next = ST_RUN;
                        end
                    end
                    fbde_pkg::CMD_BLIT_START:
                    begin
                        borg_x_next = x_reg;
                        borg_y_next = y_reg;
                        bw_next     = w_reg;
                        bh_next     = h_reg;
                        bcol_next   = '0;
                        brow_next   = '0;
                    end
                    fbde_pkg::CMD_BLIT_PIXEL:
                    begin
                        if (bact)
                        begin
                            res_ok_next = bin;
                            if (bwrap)
                            begin
                                bcol_next = '0;
                                brow_next = brow_reg + 1'b1;
                            end
                            else
                                bcol_next = bcol_inc[RW-1:0];
                            if (bdraw)
                            begin
                                op_next.valid = 1'b1;
                                op_next.write = 1'b1;
                                op_next.last  = 1'b1;
                                op_next.px    = bpx[DW-1:0];
                                op_next.py    = bpy[DW-1:0];
                                state_next    = ST_WAIT;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            ST_RUN:
            begin
                op_next.valid = 1'b1;
                op_next.write = 1'b1;
                op_next.last  = run_last;
                op_next.raw   = raw_reg;
                op_next.px    = cx_reg;
                op_next.py    = cy_reg;
                op_next.word_idx[RB-1:0] = word_reg;
                if (raw_reg)
                    word_next = word_reg + 1'b1;
                else if (cx_reg == x1m_reg)
                begin
                    cx_next = x0_reg;
                    cy_next = cy_reg + 1'b1;
                end
                else
                    cx_next = cx_reg + 1'b1;
                if (run_last)
                    state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (resp.valid)
                begin
                    if (cmd_reg == fbde_pkg::CMD_GET)
                        res_value_next = resp.data;
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    out_value_next = res_value_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= '0;
            m_valid_reg <= 1'b0;
            borg_x_reg  <= '0;
            borg_y_reg  <= '0;
            bw_reg      <= '0;
            bh_reg      <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
            borg_x_reg  <= borg_x_next;
            borg_y_reg  <= borg_y_next;
            bw_reg      <= bw_next;
            bh_reg      <= bh_next;
            bcol_reg    <= bcol_next;
            brow_reg    <= brow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        color_reg     <= color_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        x0_reg        <= x0_next;
        x1m_reg       <= x1m_next;
        y1m_reg       <= y1m_next;
        raw_reg       <= raw_next;
        word_reg      <= word_next;
        word_last_reg <= word_last_next;
        res_value_reg <= res_value_next;
        res_ok_reg    <= res_ok_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
    end

    fbde_store #(
        .FB_BYTES (FB_BYTES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_reg),
        .pitch (pitch_reg),
        .busy  (store_busy),
        .resp  (resp)
    );

endmodule

`default_nettype wire

/* rtl/core/fbde_checker.sv */
// Port-level checks for the draw engine, bound to the top level.
`default_nettype none

module fbde_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [fbde_pkg::M_TDATA_W-1:0]     m_tdata
);

    // pixel value is zero unless the pixel was on screen
    a_value_zero_off_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == '0)
        else $error("pixel value set for off-screen result");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind framebuffer_draw_engine_unit fbde_checker u_fbde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/framebuffer_draw_engine_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench for the framebuffer draw engine with a byte-level pixel predictor.
module framebuffer_draw_engine_unit_tb;

    import fbde_pkg::*;

    localparam int STORE_BYTES = FB_BYTES_DEF;
    localparam logic [CMD_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [CMD_W-1:0] OP_RESERVED_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]   op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [31:0]        color;
    } draw_req_t;

    typedef struct {
        logic [31:0] value;
        logic        hit;
    } pix_result_t;

    typedef struct {
        draw_req_t   req;
        bit          typed;
        pix_result_t want;
    } script_row_t;

    typedef struct {
        logic [14:0] w;
        logic [14:0] h;
        logic [14:0] pitch;
        logic [14:0] pb;
        int          items;
    } screen_cfg_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    framebuffer_draw_engine_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the engine state
    bit [7:0]           store_mem [STORE_BYTES];
    int                 scr_w = WIDTH_RST;
    int                 scr_h = HEIGHT_RST;
    int                 pitch = PITCH_RST;
    int                 pix_bytes = PB_RST;
    logic signed [15:0] bl_x = '0;
    logic signed [15:0] bl_y = '0;
    int                 bl_w = 0;
    int                 bl_h = 0;
    int                 bl_col = 0;
    int                 bl_row = 0;

    pix_result_t results_due [$];
    script_row_t script [$];
    screen_cfg_t plan [7];
    pix_result_t head;
    int          mismatches = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit visible(input int x, input int y);
        return x >= 0 && y >= 0 && x < scr_w && y < scr_h;
    endfunction

    function automatic longint addr_of(input int x, input int y);
        return longint'(y) * pitch + longint'(x) * ((pix_bytes == 4) ? 4 : 3);
    endfunction

    function automatic void poke(input longint a, input logic [7:0] v);
        if (a < STORE_BYTES)
            store_mem[a] = v;
    endfunction

    function automatic logic [7:0] fetch(input longint a);
        return (a < STORE_BYTES) ? store_mem[a] : 8'h00;
    endfunction

    function automatic void plot(input int x, input int y, input logic [31:0] c);
        longint a;
        a = addr_of(x, y);
        poke(a, c[7:0]);
        poke(a + 1, c[15:8]);
        poke(a + 2, c[23:16]);
        if (pix_bytes == 4)
            poke(a + 3, c[31:24]);
    endfunction

    function automatic logic [31:0] peek(input int x, input int y);
        longint      a;
        logic [31:0] v;
        a = addr_of(x, y);
        v = {8'h00, fetch(a + 2), fetch(a + 1), fetch(a)};
        if (pix_bytes == 4)
            v[31:24] = fetch(a + 3);
        return v;
    endfunction

    function automatic void paint(input int x, input int y, input int w, input int h,
                                  input logic [31:0] c);
        longint x0, y0, x1, y1, px, py;
        x0 = x;
        y0 = y;
        x1 = x0 + w;
        y1 = y0 + h;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > scr_w) x1 = scr_w;
        if (y1 > scr_h) y1 = scr_h;
        for (py = y0; py < y1; py++)
            for (px = x0; px < x1; px++)
                plot(int'(px), int'(py), c);
    endfunction

    function automatic void wipe(input logic [31:0] c);
        longint words, i;
        if (pix_bytes == 4)
        begin
            words = longint'(pitch) * scr_h / 4;
            if (words > STORE_BYTES / 4)
                words = STORE_BYTES / 4;
            for (i = 0; i < words; i++)
            begin
                store_mem[i * 4]     = c[7:0];
                store_mem[i * 4 + 1] = c[15:8];
                store_mem[i * 4 + 2] = c[23:16];
                store_mem[i * 4 + 3] = c[31:24];
            end
        end
        else
            paint(0, 0, scr_w, scr_h, c);
    endfunction

    function automatic pix_result_t apply_draw(input draw_req_t r);
        pix_result_t res;
        int          x, y, bx, by;
        res.value = '0;
        res.hit = 1'b0;
        x = r.x;
        y = r.y;
        case (r.op)
            CMD_PUT:
                if (visible(x, y))
                begin
                    plot(x, y, r.color);
                    res.hit = 1'b1;
                end
            CMD_GET:
                if (visible(x, y))
                begin
                    res.value = peek(x, y);
                    res.hit = 1'b1;
                end
            CMD_FILL:
                paint(x, y, r.w, r.h, r.color);
            CMD_CLEAR:
                wipe(r.color);
            CMD_BLIT_START:
            begin
                bl_x = r.x;
                bl_y = r.y;
                bl_w = r.w;
                bl_h = r.h;
                bl_col = 0;
                bl_row = 0;
            end
            CMD_BLIT_PIXEL:
                if (bl_w != 0 && bl_row < bl_h)
                begin
                    bx = int'(bl_x) + bl_col;
                    by = int'(bl_y) + bl_row;
                    if (visible(bx, by))
                    begin
                        res.hit = 1'b1;
                        if (r.color != COLOR_KEY)
                            plot(bx, by, r.color);
                    end
                    bl_col++;
                    if (bl_col >= bl_w)
                    begin
                        bl_col = 0;
                        bl_row++;
                    end
                end
            default: ;
        endcase
        return res;
    endfunction

    // mostly near the visible area, sometimes anywhere in the coordinate space
    function automatic logic signed [15:0] near_coord(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, ((lim < 40) ? lim : 40) + 3) - 2;
        else if (r < 9)
            return $urandom_range(0, lim + 3) - 2;
        return $urandom();
    endfunction

    function automatic draw_req_t make_req(input logic [CMD_W-1:0] op);
        draw_req_t r;
        r.op = op;
        r.x = near_coord(scr_w);
        r.y = near_coord(scr_h);
        r.w = $urandom();
        r.h = $urandom();
        r.color = $urandom();
        if ($urandom_range(0, 7) == 0)
            r.color = COLOR_KEY;
        case (op)
            CMD_FILL:
                case ($urandom_range(0, 9))
                    0:
                    begin
                        r.w = $urandom_range(0, 4095);
                        r.h = $urandom_range(0, 2);
                    end
                    1:
                    begin
                        r.w = $urandom_range(0, 2);
                        r.h = $urandom_range(0, 4095);
                    end
                    default:
                    begin
                        r.w = $urandom_range(0, 12);
                        r.h = $urandom_range(0, 12);
                    end
                endcase
            CMD_BLIT_START:
            begin
                r.w = $urandom_range(0, 6);
                r.h = $urandom_range(0, 5);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] op, input int x, input int y,
                                    input int w, input int h, input logic [31:0] color,
                                    input bit typed, input logic [31:0] value, input bit hit);
        script_row_t row;
        row.req.op = op;
        row.req.x = x;
        row.req.y = y;
        row.req.w = w;
        row.req.h = h;
        row.req.color = color;
        row.typed = typed;
        row.want.value = value;
        row.want.hit = hit;
        script.push_back(row);
    endfunction

    task automatic send(input draw_req_t req, input bit typed, input logic [31:0] value,
                        input bit hit);
        int          gap;
        bit          hold;
        pix_result_t got;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        hold = !calm && $urandom_range(0, 79) == 0;
        if (hold && gap == 0)
            gap = 1;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (hold && results_due.size() != 0)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {req.color, req.h, req.w, req.y, req.x};
        s_tuser <= req.op;
        do @(posedge clk); while (!s_tready);
        got = apply_draw(req);
        if (typed)
        begin
            got.value = value;
            got.hit = hit;
        end
        results_due.push_back(got);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WIDTH:       scr_w = val[DIM_W-1:0];
            CFG_HEIGHT:      scr_h = val[DIM_W-1:0];
            CFG_PITCH:       pitch = val;
            CFG_PIXEL_BYTES: pix_bytes = val[PB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_screen(input screen_cfg_t p);
        write_reg(CFG_WIDTH, p.w);
        write_reg(CFG_HEIGHT, p.h);
        write_reg(CFG_PITCH, p.pitch);
        write_reg(CFG_PIXEL_BYTES, p.pb);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n);
        draw_req_t        r;
        logic [CMD_W-1:0] op;
        int               base, k, cnt, i;
        longint           cost;
        bit               cut;
        base = items_sent;
        while (items_sent - base < n)
        begin
            k = $urandom_range(0, 99);
            if (k < 22)
                send(make_req(CMD_PUT), 1'b0, '0, 1'b0);
            else if (k < 44)
                send(make_req(CMD_GET), 1'b0, '0, 1'b0);
            else if (k < 54)
                send(make_req(CMD_FILL), 1'b0, '0, 1'b0);
            else if (k == 54)
            begin
                cost = (pix_bytes == 4) ? longint'(pitch) * scr_h / 4
                                        : longint'(scr_w) * scr_h;
                send(make_req((cost <= 70000) ? CMD_CLEAR : CMD_GET), 1'b0, '0, 1'b0);
            end
            else if (k < 59)
            begin
                op = $urandom_range(0, 7);
                if (op == CMD_FILL || op == CMD_CLEAR)
                    op = $urandom_range(0, 1) ? OP_RESERVED_LO : OP_RESERVED_HI;
                r = make_req(op);
                r.x = $urandom();
                r.y = $urandom();
                r.w = $urandom();
                r.h = $urandom();
                send(r, 1'b0, '0, 1'b0);
            end
            else
            begin
                r = make_req(CMD_BLIT_START);
                send(r, 1'b0, '0, 1'b0);
                cnt = int'(r.w) * int'(r.h);
                cut = $urandom_range(0, 6) == 0;
                if (cut && cnt > 0)
                    cnt = $urandom_range(0, cnt - 1);
                else
                    cnt += $urandom_range(0, 1);
                for (i = 0; i < cnt; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(make_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET),
                             1'b0, '0, 1'b0);
                    send(make_req(CMD_BLIT_PIXEL), 1'b0, '0, 1'b0);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result with none due: expected none, actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                head = results_due.pop_front();
                if (m_tdata[31:0] !== head.value)
                begin
                    $display("%0t: pixel_value expected %h actual %h",
                             $time, head.value, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[32] !== head.hit)
                begin
                    $display("%0t: in_range expected %b actual %b", $time, head.hit, m_tdata[32]);
                    mismatches++;
                end
                if (m_tdata[39:33] !== '0)
                begin
                    $display("%0t: pad bits expected %h actual %h",
                             $time, 7'h00, m_tdata[39:33]);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        forever
        begin
            repeat (($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int p;
        plan[0] = '{15'h6028, 15'd30, 15'd160, 15'h7FFC, 150};
        plan[1] = '{15'd37, 15'd23, 15'd120, 15'd3, 150};
        plan[2] = '{15'd1, 15'd1, 15'd3, 15'd3, 60};
        plan[3] = '{15'd4096, 15'd4096, 15'd16384, 15'd4, 90};
        plan[4] = '{15'd0, 15'd17, 15'd64, 15'd7, 60};
        plan[5] = '{15'd50, 15'd40, 15'd300, 15'd0, 110};
        plan[6] = '{15'd96, 15'd64, 15'd384, 15'd4, 80};

        // reset screen: 256 x 256, 32-bit pixels
        add_row(CMD_GET, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b1);
        add_row(CMD_PUT, 0, 0, 4095, 4095, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1);
        add_row(CMD_GET, 0, 0, 0, 0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        add_row(CMD_PUT, 255, 255, 0, 0, 32'h1234_5678, 1'b1, 32'h0, 1'b1);
        add_row(CMD_GET, 255, 255, 0, 0, 32'h0, 1'b1, 32'h1234_5678, 1'b1);
        add_row(CMD_PUT, 256, 0, 0, 0, 32'hDEAD_BEEF, 1'b1, 32'h0, 1'b0);
        add_row(CMD_GET, -1, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
        add_row(CMD_GET, -32768, 32767, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
        add_row(CMD_PUT, 32767, -32768, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
        add_row(CMD_FILL, -2, -2, 6, 5, 32'hA5A5_A5A5, 1'b1, 32'h0, 1'b0);
        add_row(CMD_GET, 3, 2, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
        add_row(CMD_FILL, 250, 254, 4095, 2, 32'hC3C3_C3C3, 1'b1, 32'h0, 1'b0);
        add_row(CMD_GET, 255, 255, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
        add_row(CMD_FILL, 10, 10, 0, 4095, 32'h7777_7777, 1'b1, 32'h0, 1'b0);
        add_row(CMD_BLIT_START, 254, -1, 3, 2, 32'h0, 1'b1, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 0, 0, 0, 0, 32'h1111_1111, 1'b0, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 0, 0, 0, 0, 32'h2222_2222, 1'b0, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 0, 0, 0, 0, 32'h3333_3333, 1'b0, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 0, 0, 0, 0, COLOR_KEY, 1'b0, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 0, 0, 0, 0, 32'h5A5A_5A5A, 1'b0, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 0, 0, 0, 0, 32'h6666_6666, 1'b0, 32'h0, 1'b0);
        add_row(CMD_BLIT_PIXEL, 255, 0, 0, 0, 32'h9999_9999, 1'b1, 32'h0, 1'b0);
        add_row(CMD_GET, 255, 0, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
        add_row(OP_RESERVED_HI, -1, -1, 4095, 4095, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
        add_row(CMD_GET, 255, 255, 0, 0, 32'h0, 1'b1, 32'h0, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send(script[i].req, script[i].typed, script[i].want.value, script[i].want.hit);

        for (p = 0; p < 7; p++)
        begin
            settle();
            program_screen(plan[p]);
            if (p == 6)
                calm = 1'b1;
            run_phase(plan[p].items);
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
